>>> rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the timer capture/compare unit.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Default counter width and value ranges
  localparam int unsigned CounterWidthDflt = 16;
  localparam int unsigned RegW             = 16;
  localparam int unsigned CfgIdxW          = 4;

  // Reset value of the auto-reload register
  localparam logic [RegW-1:0] AutoReloadRst = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPrescaler     = 4'd0;
  localparam logic [CfgIdxW-1:0] RegAutoReload    = 4'd1;
  localparam logic [CfgIdxW-1:0] RegCompareValue  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegCountEnable   = 4'd3;
  localparam logic [CfgIdxW-1:0] RegOneShot       = 4'd4;
  localparam logic [CfgIdxW-1:0] RegCaptureEnable = 4'd5;
  localparam logic [CfgIdxW-1:0] RegCaptureFall   = 4'd6;
  localparam logic [CfgIdxW-1:0] RegUpdIrqEnable  = 4'd7;

  // Configuration register set
  typedef struct packed {
    logic [RegW-1:0] prescaler;
    logic [RegW-1:0] auto_reload;
    logic [RegW-1:0] compare_value;
    logic            count_enable;
    logic            one_shot;
    logic            capture_enable;
    logic            capture_on_falling;
    logic            update_irq_enable;
  } cfg_t;

  // Input item controls
  typedef struct packed {
    logic capture_pin;
    logic clear_update_flag;
    logic clear_capture;
    logic restart;
  } tick_t;

  // Counter flags after the tick
  typedef struct packed {
    logic wrap_flag;
    logic run_flag;
  } cnt_flags_t;

  // Capture results after the tick
  typedef struct packed {
    logic [RegW-1:0] capture_value;
    logic [RegW-1:0] period;
    logic            period_valid;
  } cap_res_t;

endpackage

>>> rtl/tcc_counter.sv
// ----------------------------------------------------------------------------
// tcc_counter
// Prescaler, up counter with auto-reload wrap, run flag and update flag.
// ----------------------------------------------------------------------------
module tcc_counter #(
  parameter int unsigned CounterWidth = tcc_pkg::CounterWidthDflt
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  tcc_pkg::tick_t          tick_i,
  input  tcc_pkg::cfg_t           cfg_i,
  output logic [CounterWidth-1:0] cnt_d_o,
  output tcc_pkg::cnt_flags_t     flags_d_o
);

  localparam int unsigned CmpW = (CounterWidth > tcc_pkg::RegW) ? CounterWidth
                                                                 : tcc_pkg::RegW;

  logic [tcc_pkg::RegW-1:0] pre_q, pre_d;
  logic [CounterWidth-1:0]  cnt_q, cnt_d;
  logic                     run_q, run_d;
  logic                     wrap_q, wrap_d;
  logic                     wrapped;
  logic                     at_top;

  // Wrap when reaching auto-reload or the counter's own maximum
  assign at_top = (CmpW'(cnt_q) >= CmpW'(cfg_i.auto_reload)) || (&cnt_q);

  // Next state for one tick
  always_comb begin
    pre_d   = pre_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    wrapped = 1'b0;
    if (tick_i.restart) begin
      pre_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (cfg_i.count_enable && run_q) begin
      if (pre_q >= cfg_i.prescaler) begin
        pre_d = '0;
        if (at_top) begin
          cnt_d   = '0;
          wrapped = 1'b1;
          if (cfg_i.one_shot) begin
            run_d = 1'b0;
          end
        end else begin
          cnt_d = cnt_q + CounterWidth'(1);
        end
      end else begin
        pre_d = pre_q + 16'd1;
      end
    end
    // A wrap in the same tick wins over the clear
    wrap_d = wrapped | (wrap_q & ~tick_i.clear_update_flag);
  end

  // Advance state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b1;
      wrap_q <= 1'b0;
    end else if (accept_i) begin
      pre_q  <= pre_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      wrap_q <= wrap_d;
    end
  end

  assign cnt_d_o             = cnt_d;
  assign flags_d_o.wrap_flag = wrap_d;
  assign flags_d_o.run_flag  = run_d;

endmodule

>>> rtl/tcc_capture.sv
// ----------------------------------------------------------------------------
// tcc_capture
// Pin edge detect, count capture and two-capture period measurement.
// ----------------------------------------------------------------------------
module tcc_capture (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  tcc_pkg::tick_t             tick_i,
  input  tcc_pkg::cfg_t              cfg_i,
  input  logic [tcc_pkg::RegW-1:0]   cnt_i,
  output tcc_pkg::cap_res_t          res_d_o
);

  logic                     prev_pin_q;
  logic [tcc_pkg::RegW-1:0] latch_q, latch_d;
  logic [tcc_pkg::RegW-1:0] first_q, first_d;
  logic [tcc_pkg::RegW-1:0] period_q, period_d;
  logic                     phase_q, phase_d;
  logic                     done_q, done_d;
  logic                     edge_hit;

  // Select the active pin edge
  assign edge_hit = cfg_i.capture_on_falling ? (prev_pin_q & ~tick_i.capture_pin)
                                             : (~prev_pin_q & tick_i.capture_pin);

  // Clear acts first, then a capture may start a new pair
  always_comb begin
    latch_d  = latch_q;
    first_d  = first_q;
    period_d = period_q;
    phase_d  = phase_q;
    done_d   = done_q;
    if (tick_i.clear_capture) begin
      done_d  = 1'b0;
      phase_d = 1'b0;
    end
    if (cfg_i.capture_enable && edge_hit) begin
      latch_d = cnt_i;
      if (!done_d) begin
        if (!phase_d) begin
          first_d = cnt_i;
          phase_d = 1'b1;
        end else begin
          period_d = cnt_i - first_q;
          phase_d  = 1'b0;
          done_d   = 1'b1;
        end
      end
    end
  end

  // Hold capture state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pin_q <= 1'b0;
      latch_q    <= '0;
      first_q    <= '0;
      period_q   <= '0;
      phase_q    <= 1'b0;
      done_q     <= 1'b0;
    end else if (accept_i) begin
      prev_pin_q <= tick_i.capture_pin;
      latch_q    <= latch_d;
      first_q    <= first_d;
      period_q   <= period_d;
      phase_q    <= phase_d;
      done_q     <= done_d;
    end
  end

  assign res_d_o.capture_value = latch_d;
  assign res_d_o.period        = period_d;
  assign res_d_o.period_valid  = done_d;

endmodule

>>> rtl/timer_capture_compare_unit_core.sv
// ----------------------------------------------------------------------------
// timer_capture_compare_unit_core
// 16-bit up-counting timer with prescaler, PWM compare and input capture.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_axis channel is one kernel-clock tick and carries the
//   pin level and the clear/restart controls. Each accepted item yields
//   exactly one result item on m_axis with the timer state after that tick.
//   Configuration registers are written through cfg_valid_i/cfg_index_i/
//   cfg_data_i; cfg_ready_o is always high. Write them only while idle.
//   Result: a result is valid in the cycle after its item is accepted.
//   Throughput: one item per cycle unless m_axis stalls; the state update
//   and the result are computed in one pass and held in the output register.
//   Stall: while the receiver holds m_axis_tready low and a result waits,
//   s_axis_tready is low and the result holds.
//   Reset: counter, prescaler and capture state clear, the run flag sets,
//   auto_reload returns to 0xFFFF and all other registers to zero.
// ----------------------------------------------------------------------------
module timer_capture_compare_unit_core #(
  parameter int unsigned CounterWidth = tcc_pkg::CounterWidthDflt
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tdata: capture_pin[0], clear_update_flag[1], clear_capture[2], restart[3]
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,
  // tdata: count[15:0], remaining[31:16], update_flag[32], irq[33],
  //        pwm_out[34], capture_value[50:35], period[66:51],
  //        period_valid[67], running[68]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [71:0]                 m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tcc_pkg::RegW-1:0]    cfg_data_i
);

  localparam int unsigned CmpW = (CounterWidth > tcc_pkg::RegW) ? CounterWidth
                                                                 : tcc_pkg::RegW;

  tcc_pkg::cfg_t           cfg_q;
  tcc_pkg::tick_t          tick;
  tcc_pkg::cnt_flags_t     flags_d;
  tcc_pkg::cap_res_t       cap_d;
  logic [CounterWidth-1:0] cnt_d;
  logic [CmpW-1:0]         cnt_ext;
  logic [CmpW-1:0]         ar_ext;
  logic [15:0]             remaining;
  logic                    pwm;
  logic                    accept;
  logic                    out_valid_q;
  logic [71:0]             out_data_q, out_data_d;

  // Unpack the input item
  assign tick.capture_pin       = s_axis_tdata[0];
  assign tick.clear_update_flag = s_axis_tdata[1];
  assign tick.clear_capture     = s_axis_tdata[2];
  assign tick.restart           = s_axis_tdata[3];

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescaler          <= '0;
      cfg_q.auto_reload        <= tcc_pkg::AutoReloadRst;
      cfg_q.compare_value      <= '0;
      cfg_q.count_enable       <= 1'b0;
      cfg_q.one_shot           <= 1'b0;
      cfg_q.capture_enable     <= 1'b0;
      cfg_q.capture_on_falling <= 1'b0;
      cfg_q.update_irq_enable  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tcc_pkg::RegPrescaler:     cfg_q.prescaler          <= cfg_data_i;
        tcc_pkg::RegAutoReload:    cfg_q.auto_reload        <= cfg_data_i;
        tcc_pkg::RegCompareValue:  cfg_q.compare_value      <= cfg_data_i;
        tcc_pkg::RegCountEnable:   cfg_q.count_enable       <= cfg_data_i[0];
        tcc_pkg::RegOneShot:       cfg_q.one_shot           <= cfg_data_i[0];
        tcc_pkg::RegCaptureEnable: cfg_q.capture_enable     <= cfg_data_i[0];
        tcc_pkg::RegCaptureFall:   cfg_q.capture_on_falling <= cfg_data_i[0];
        tcc_pkg::RegUpdIrqEnable:  cfg_q.update_irq_enable  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  tcc_counter #(
    .CounterWidth(CounterWidth)
  ) u_counter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .tick_i    (tick),
    .cfg_i     (cfg_q),
    .cnt_d_o   (cnt_d),
    .flags_d_o (flags_d)
  );

  tcc_capture u_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .tick_i   (tick),
    .cfg_i    (cfg_q),
    .cnt_i    (16'(cnt_d)),
    .res_d_o  (cap_d)
  );

  // Derive compare outputs from the count after this tick
  assign cnt_ext   = CmpW'(cnt_d);
  assign ar_ext    = CmpW'(cfg_q.auto_reload);
  assign remaining = (ar_ext > cnt_ext) ? 16'(ar_ext - cnt_ext) : 16'd0;
  assign pwm       = cnt_ext < CmpW'(cfg_q.compare_value);

  // Pack the result item
  always_comb begin
    out_data_d        = '0;
    out_data_d[15:0]  = 16'(cnt_d);
    out_data_d[31:16] = remaining;
    out_data_d[32]    = flags_d.wrap_flag;
    out_data_d[33]    = flags_d.wrap_flag & cfg_q.update_irq_enable;
    out_data_d[34]    = pwm;
    out_data_d[50:35] = cap_d.capture_value;
    out_data_d[66:51] = cap_d.period;
    out_data_d[67]    = cap_d.period_valid;
    out_data_d[68]    = flags_d.run_flag & cfg_q.count_enable;
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  // No new item while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("item accepted over a stalled result");

  // irq only with the update flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_data_q[33] || out_data_q[32]))
    else $error("irq without update flag");

  // Restart leaves the count at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tdata[3]) |=> (out_data_q[15:0] == 16'd0))
    else $error("restart did not zero the count");

  // Each accept yields a valid result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("result missing after accept");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timer capture/compare core. A tick-exact
// predictor of the counter, prescaler, PWM and capture logic runs beside the
// block, and every result item is compared field by field with it. Directed
// tests cover reset behavior, wraps, one-shot, capture pairs and the largest
// reload value. Random runs follow, with random register settings and idle
// and stall patterns on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned ChunkItems  = 105;

  // Result item as laid out on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [2:0]  pad;
    logic        running;
    logic        period_valid;
    logic [15:0] period;
    logic [15:0] capture_value;
    logic        pwm_out;
    logic        irq;
    logic        update_flag;
    logic [15:0] remaining;
    logic [15:0] count;
  } timer_out_t;

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        s_valid   = 1'b0;
  logic [7:0]                  s_data    = '0;
  logic                        s_axis_tready;
  logic                        m_axis_tvalid;
  logic                        m_ready   = 1'b0;
  logic [71:0]                 m_axis_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready_o;
  logic [tcc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [tcc_pkg::RegW-1:0]    cfg_data  = '0;

  // Idle and stall odds in percent per cycle
  int unsigned src_idle = 0;
  int unsigned snk_idle = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Predicted timer state and register copy
  tcc_pkg::cfg_t regs;
  logic [15:0]   pre_cnt, cnt_val, cap_latch, cap_first, period_val;
  logic          run_q, wrap_q, pin_q, cap_phase, pair_q;

  timer_out_t  timer_snapshots[$];

  timer_capture_compare_unit_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Advance the predicted timer by one tick and return the result item
  function automatic timer_out_t tick_timer(input tcc_pkg::tick_t t);
    timer_out_t o;
    logic       wrapped;
    logic       hit;
    o = '0;
    wrapped = 1'b0;
    if (t.restart) begin
      pre_cnt = '0;
      cnt_val = '0;
      run_q   = 1'b1;
    end else if (regs.count_enable && run_q) begin
      if (pre_cnt >= regs.prescaler) begin
        pre_cnt = '0;
        if (cnt_val >= regs.auto_reload || cnt_val == 16'hFFFF) begin
          cnt_val = '0;
          wrapped = 1'b1;
          if (regs.one_shot) run_q = 1'b0;
        end else begin
          cnt_val = cnt_val + 16'd1;
        end
      end else begin
        pre_cnt = pre_cnt + 16'd1;
      end
    end
    // A wrap in the same tick wins over the clear
    if (t.clear_update_flag) wrap_q = 1'b0;
    if (wrapped) wrap_q = 1'b1;
    // Rearm the pair before any capture in this tick
    if (t.clear_capture) begin
      pair_q    = 1'b0;
      cap_phase = 1'b0;
    end
    hit = regs.capture_on_falling ? (pin_q && !t.capture_pin)
                                  : (!pin_q && t.capture_pin);
    pin_q = t.capture_pin;
    if (regs.capture_enable && hit) begin
      cap_latch = cnt_val;
      if (!pair_q) begin
        if (!cap_phase) begin
          cap_first = cap_latch;
          cap_phase = 1'b1;
        end else begin
          period_val = cap_latch - cap_first;
          cap_phase  = 1'b0;
          pair_q     = 1'b1;
        end
      end
    end
    o.count         = cnt_val;
    o.remaining     = (regs.auto_reload > cnt_val) ? regs.auto_reload - cnt_val : '0;
    o.update_flag   = wrap_q;
    o.irq           = wrap_q & regs.update_irq_enable;
    o.pwm_out       = cnt_val < regs.compare_value;
    o.capture_value = cap_latch;
    o.period        = period_val;
    o.period_valid  = pair_q;
    o.running       = run_q & regs.count_enable;
    return o;
  endfunction

  function automatic string fmt_out(input timer_out_t o);
    return $sformatf("count=%h rem=%h upd=%b irq=%b pwm=%b cap=%h per=%h pv=%b run=%b",
                     o.count, o.remaining, o.update_flag, o.irq, o.pwm_out,
                     o.capture_value, o.period, o.period_valid, o.running);
  endfunction

  // Take result items and compare them with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    timer_out_t act;
    timer_out_t exp_out;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        act = m_axis_tdata;
        if (timer_snapshots.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result item: %s", fmt_out(act));
        end else begin
          exp_out = timer_snapshots.pop_front();
          if (act.count !== exp_out.count || act.remaining !== exp_out.remaining ||
              act.update_flag !== exp_out.update_flag || act.irq !== exp_out.irq ||
              act.pwm_out !== exp_out.pwm_out ||
              act.capture_value !== exp_out.capture_value ||
              act.period !== exp_out.period ||
              act.period_valid !== exp_out.period_valid ||
              act.running !== exp_out.running) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch at %0t\n  exp %s\n  act %s", $realtime,
                       fmt_out(exp_out), fmt_out(act));
          end
        end
      end
      m_ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  // Send one tick item and predict its result on acceptance
  task automatic send_tick(input tcc_pkg::tick_t t);
    while ($urandom_range(0, 99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {4'b0, t.restart, t.clear_capture, t.clear_update_flag, t.capture_pin};
    do @(posedge clk_i); while (!s_axis_tready);
    timer_snapshots.push_back(tick_timer(t));
  endtask

  task automatic tick(input logic pin, input logic clr_upd, input logic clr_cap,
                      input logic rs);
    tcc_pkg::tick_t t;
    t.capture_pin       = pin;
    t.clear_update_flag = clr_upd;
    t.clear_capture     = clr_cap;
    t.restart           = rs;
    send_tick(t);
  endtask

  // Hold off the sender until every predicted item has come back
  task automatic drain();
    s_valid <= 1'b0;
    while (timer_snapshots.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tcc_pkg::CfgIdxW-1:0] idx,
                           input logic [tcc_pkg::RegW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tcc_pkg::RegPrescaler:     regs.prescaler          = val;
      tcc_pkg::RegAutoReload:    regs.auto_reload        = val;
      tcc_pkg::RegCompareValue:  regs.compare_value      = val;
      tcc_pkg::RegCountEnable:   regs.count_enable       = val[0];
      tcc_pkg::RegOneShot:       regs.one_shot           = val[0];
      tcc_pkg::RegCaptureEnable: regs.capture_enable     = val[0];
      tcc_pkg::RegCaptureFall:   regs.capture_on_falling = val[0];
      tcc_pkg::RegUpdIrqEnable:  regs.update_irq_enable  = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_all(input tcc_pkg::cfg_t c);
    write_reg(tcc_pkg::RegPrescaler,     c.prescaler);
    write_reg(tcc_pkg::RegAutoReload,    c.auto_reload);
    write_reg(tcc_pkg::RegCompareValue,  c.compare_value);
    write_reg(tcc_pkg::RegCountEnable,   16'(c.count_enable));
    write_reg(tcc_pkg::RegOneShot,       16'(c.one_shot));
    write_reg(tcc_pkg::RegCaptureEnable, 16'(c.capture_enable));
    write_reg(tcc_pkg::RegCaptureFall,   16'(c.capture_on_falling));
    write_reg(tcc_pkg::RegUpdIrqEnable,  16'(c.update_irq_enable));
  endtask

  // Mostly short periods and small dividers, with the extremes now and then
  function automatic tcc_pkg::cfg_t rand_cfg();
    tcc_pkg::cfg_t c;
    int unsigned   pick;
    int unsigned   lim;
    pick = $urandom_range(0, 9);
    if (pick <= 5)      c.prescaler = 16'($urandom_range(0, 2));
    else if (pick <= 7) c.prescaler = '0;
    else if (pick == 8) c.prescaler = 16'hFFFF;
    else                c.prescaler = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 9);
    if (pick <= 5)      c.auto_reload = 16'($urandom_range(1, 40));
    else if (pick == 6) c.auto_reload = '0;
    else if (pick == 7) c.auto_reload = 16'hFFFF;
    else if (pick == 8) c.auto_reload = 16'($urandom_range(0, 65535));
    else                c.auto_reload = 16'($urandom_range(0, 4));
    lim = (c.auto_reload > 60) ? 61 : c.auto_reload + 1;
    pick = $urandom_range(0, 9);
    if (pick <= 5)      c.compare_value = 16'($urandom_range(0, lim));
    else if (pick == 6) c.compare_value = '0;
    else if (pick == 7) c.compare_value = 16'hFFFF;
    else                c.compare_value = 16'($urandom_range(0, 65535));
    c.count_enable       = ($urandom_range(0, 9) != 0);
    c.one_shot           = 1'($urandom_range(0, 1));
    c.capture_enable     = ($urandom_range(0, 3) != 0);
    c.capture_on_falling = 1'($urandom_range(0, 1));
    c.update_irq_enable  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Pin high on the first tick after reset counts as a rising edge
  task automatic test_first_edge();
    write_reg(tcc_pkg::RegCaptureEnable, 16'd1);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_directed();
    tcc_pkg::cfg_t c;
    src_idle = 26;
    snk_idle = 26;
    c = '0;
    c.auto_reload       = 16'd3;
    c.compare_value     = 16'd2;
    c.count_enable      = 1'b1;
    c.capture_enable    = 1'b1;
    c.update_irq_enable = 1'b1;
    program_all(c);
    // A completed pair, then a wrap with a clear in the same tick
    tick(1'b0, 1'b0, 1'b0, 1'b1);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b1, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b1, 1'b1, 1'b0);
    tick(1'b1, 1'b0, 1'b1, 1'b0);
    drain();
    // Lower the reload below the running count
    write_reg(tcc_pkg::RegAutoReload, 16'hFFFF);
    repeat (6) tick(1'b0, 1'b0, 1'b0, 1'b0);
    drain();
    write_reg(tcc_pkg::RegAutoReload, 16'd2);
    write_reg(tcc_pkg::RegPrescaler, 16'd1);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    drain();
    // One-shot stop, capture on a frozen count, then restart
    write_reg(tcc_pkg::RegOneShot, 16'd1);
    repeat (4) tick(1'b1, 1'b0, 1'b1, 1'b0);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0, 1'b1);
    drain();
    // Falling edges with the counter disabled, full compare
    write_reg(tcc_pkg::RegCaptureFall, 16'd1);
    write_reg(tcc_pkg::RegCompareValue, 16'hFFFF);
    write_reg(tcc_pkg::RegCountEnable, 16'd0);
    tick(1'b1, 1'b0, 1'b1, 1'b0);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    drain();
    // Largest divider
    write_reg(tcc_pkg::RegPrescaler, 16'hFFFF);
    write_reg(tcc_pkg::RegCountEnable, 16'd1);
    write_reg(tcc_pkg::RegUpdIrqEnable, 16'd0);
    tick(1'b0, 1'b1, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    drain();
  endtask

  // Run the counter from restart with the largest reload value
  task automatic test_max_reload();
    tcc_pkg::cfg_t c;
    src_idle = 0;
    snk_idle = 0;
    c = '0;
    c.auto_reload       = 16'hFFFF;
    c.compare_value     = 16'h0010;
    c.count_enable      = 1'b1;
    c.capture_enable    = 1'b1;
    c.update_irq_enable = 1'b1;
    program_all(c);
    tick(1'b0, 1'b0, 1'b1, 1'b1);
    repeat (40) tick(1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_random();
    int unsigned    src_tbl[4];
    int unsigned    snk_tbl[4];
    tcc_pkg::tick_t t;
    src_tbl = '{0, 82, 0, 26};
    snk_tbl = '{0, 0, 82, 26};
    for (int p = 0; p < 4; p++) begin
      src_idle = src_tbl[p];
      snk_idle = snk_tbl[p];
      repeat (4) begin
        program_all(rand_cfg());
        repeat (ChunkItems) begin
          t.capture_pin       = 1'($urandom_range(0, 1));
          t.clear_update_flag = ($urandom_range(0, 7) == 0);
          t.clear_capture     = ($urandom_range(0, 9) == 0);
          t.restart           = ($urandom_range(0, 29) == 0);
          send_tick(t);
        end
        drain();
      end
    end
  endtask

  initial begin
    regs = '0;
    regs.auto_reload = tcc_pkg::AutoReloadRst;
    pre_cnt    = '0;
    cnt_val    = '0;
    cap_latch  = '0;
    cap_first  = '0;
    period_val = '0;
    run_q      = 1'b1;
    wrap_q     = 1'b0;
    pin_q      = 1'b0;
    cap_phase  = 1'b0;
    pair_q     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_edge();
    test_directed();
    test_max_reload();
    test_random();
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && timer_snapshots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
